@@ src/vsh_pkg.sv @@
// Shared types and constants for the voxel store with height map.
`timescale 1ns / 1ps
package vsh_pkg;

  localparam logic [2:0] OP_RD_VOX = 3'd0;
  localparam logic [2:0] OP_WR_VOX = 3'd1;
  localparam logic [2:0] OP_RD_HGT = 3'd2;
  localparam logic [2:0] OP_SET_HGT = 3'd3;
  localparam logic [2:0] OP_CLR_MOD = 3'd4;

  // Reset value of floor_y and of every column height (-64).
  localparam logic signed [11:0] FLOOR_RESET = -12'sd64;
  localparam logic signed [12:0] HEIGHT_RESET = -13'sd64;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_EXEC,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_WRH
  } state_t;

  typedef struct packed {
    logic clr_en;
    logic load;
    logic rd;
    logic exec;
    logic scan_rd;
    logic scan_dec;
    logic wr_h;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic scan_need;
    logic h_gt_floor;
    logic scan_zero;
    logic clr_last;
  } sts_t;

endpackage

@@ src/vsh_in_if.sv @@
// Request channel: operation word with valid/ready handshake.
`timescale 1ns / 1ps
interface vsh_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic [3:0]         col_x;
  logic signed [12:0] pos_y;
  logic [3:0]         col_z;
  logic [11:0]        new_block;
  logic signed [12:0] new_height;

  modport source(output valid, opcode, col_x, pos_y, col_z, new_block, new_height,
                 input ready);
  modport sink(input valid, opcode, col_x, pos_y, col_z, new_block, new_height,
               output ready);
endinterface

@@ src/vsh_out_if.sv @@
// Result channel: result word with valid/ready handshake.
`timescale 1ns / 1ps
interface vsh_out_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic [11:0]        block_out;
  logic signed [12:0] height_out;
  logic [12:0]        nonair_out;
  logic               dirty_out;

  modport source(output valid, status, block_out, height_out, nonair_out, dirty_out,
                 input ready);
  modport sink(input valid, status, block_out, height_out, nonair_out, dirty_out,
               output ready);
endinterface

@@ src/voxel_store_with_heightmap.sv @@
// Each accepted word passes through lookup, execute and height write-back before
// its result enters the output register; clearing the top voxel adds a downward
// scan of a read and a check per level stepped, set by the single voxel memory
// read port. One item in flight at a time: no new word is taken until the result
// is loaded. Reset: a clearing pass writes air to all SECTIONS*4096 voxels, one
// per cycle, before the first word is accepted; counts, heights and floor reset
// at once.
`timescale 1ns / 1ps
module voxel_store_with_heightmap import vsh_pkg::*; #(
  parameter int SECTIONS = 24,
  parameter int ID_BITS  = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata,
  vsh_in_if.sink      in_ch,
  vsh_out_if.source   out_ch
);

  cmd_t cmd;
  sts_t sts;

  vsh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vsh_dpath #(
    .SECTIONS (SECTIONS),
    .ID_BITS  (ID_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .opcode     (in_ch.opcode),
    .col_x      (in_ch.col_x),
    .pos_y      (in_ch.pos_y),
    .col_z      (in_ch.col_z),
    .new_block  (in_ch.new_block),
    .new_height (in_ch.new_height),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .status     (out_ch.status),
    .block_out  (out_ch.block_out),
    .height_out (out_ch.height_out),
    .nonair_out (out_ch.nonair_out),
    .dirty_out  (out_ch.dirty_out)
  );

endmodule

@@ src/vsh_ctrl.sv @@
// Controller state machine: sequences clear, lookup, execute, scan and write-back.
`timescale 1ns / 1ps
module vsh_ctrl import vsh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:    if (sts.clr_last) state_next = ST_IDLE;
      ST_IDLE:     if (in_valid) state_next = ST_LOOK;
      ST_LOOK:     state_next = ST_EXEC;
      ST_EXEC:     state_next = sts.scan_need ? ST_SCAN_RD : ST_WRH;
      ST_SCAN_RD:  state_next = sts.h_gt_floor ? ST_SCAN_CHK : ST_WRH;
      ST_SCAN_CHK: state_next = sts.scan_zero ? ST_SCAN_RD : ST_WRH;
      ST_WRH:      if (sts.out_free) state_next = ST_IDLE;
      default:     state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_CLEAR:    cmd.clr_en = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_LOOK:     cmd.rd = 1'b1;
      ST_EXEC:     cmd.exec = 1'b1;
      ST_SCAN_RD:  cmd.scan_rd = sts.h_gt_floor;
      ST_SCAN_CHK: cmd.scan_dec = sts.scan_zero;
      ST_WRH: begin
        cmd.wr_h     = 1'b1;
        cmd.out_load = sts.out_free;
      end
      default:     cmd = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_load_look: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_LOOK) else $error("load not followed by lookup");
  a_chk_after_rd: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN_CHK |-> $past(state == ST_SCAN_RD))
    else $error("scan check without scan read");
  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> state == ST_IDLE) else $error("result load did not end item");
`endif

endmodule

@@ src/vsh_dpath.sv @@
// Datapath: voxel, count and height memories, operation logic and result register.
`timescale 1ns / 1ps
module vsh_dpath import vsh_pkg::*; #(
  parameter int SECTIONS = 24,
  parameter int ID_BITS  = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [11:0]        cfg_wdata,
  input  logic [2:0]         opcode,
  input  logic [3:0]         col_x,
  input  logic signed [12:0] pos_y,
  input  logic [3:0]         col_z,
  input  logic [11:0]        new_block,
  input  logic signed [12:0] new_height,
  input  cmd_t               cmd,
  output sts_t               sts,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               status,
  output logic [11:0]        block_out,
  output logic signed [12:0] height_out,
  output logic [12:0]        nonair_out,
  output logic               dirty_out
);

  localparam int SEC_W  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int ADDR_W = SEC_W + 12;
  localparam int DEPTH  = SECTIONS * 4096;
  localparam int SPAN   = 16 * SECTIONS;

  logic signed [11:0] floor_y;
  logic [2:0]         op_r;
  logic [3:0]         x_r, z_r, ly_r;
  logic signed [12:0] y_r, nh_r;
  logic [ID_BITS-1:0] nb_r;
  logic               yok_r, nhok_r;
  logic [SEC_W-1:0]   sec_r;

  logic [ADDR_W-1:0]  clr_cnt;
  logic [ID_BITS-1:0] vox_mem [DEPTH];
  logic [ID_BITS-1:0] vox_rd;
  logic [12:0]        hmem [256];
  logic [255:0]       hvalid;
  logic [12:0]        h_rd;
  logic               hv_rd;
  logic [12:0]        cmem [SECTIONS];
  logic [SECTIONS-1:0] cvalid;
  logic [12:0]        cnt_rd;
  logic               cv_rd;

  logic signed [12:0] h_reg;
  logic [12:0]        cnt_r;
  logic [11:0]        blk_r;
  logic               status_r;
  logic               dirty;

  // Load-stage range checks.
  logic signed [13:0] y_off, nh_off;
  logic [15:0]        nb_wide;
  logic signed [12:0] floor_ext;

  assign floor_ext = {floor_y[11], floor_y};
  assign y_off   = {pos_y[12], pos_y} - {{2{floor_y[11]}}, floor_y};
  assign nh_off  = {new_height[12], new_height} - {{2{floor_y[11]}}, floor_y};
  assign nb_wide = {4'b0000, new_block};

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_y <= FLOOR_RESET;
    end else if (cfg_we) begin
      floor_y <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= opcode;
      x_r    <= col_x;
      z_r    <= col_z;
      y_r    <= pos_y;
      nh_r   <= new_height;
      nb_r   <= nb_wide[ID_BITS-1:0];
      yok_r  <= !y_off[13] && (y_off[12:0] < 13'(SPAN));
      nhok_r <= !nh_off[13] && (nh_off[12:0] < 13'(SPAN));
      sec_r  <= y_off[SEC_W+3:4];
      ly_r   <= y_off[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt <= clr_cnt + ADDR_W'(1);
    end
  end

  // Scan address from the current height.
  logic signed [13:0] scan_off;
  logic [ADDR_W-1:0]  item_addr, scan_addr;
  logic [7:0]         col;

  assign scan_off  = {h_reg[12], h_reg} - {{2{floor_y[11]}}, floor_y};
  assign item_addr = {sec_r, ly_r, z_r, x_r};
  assign scan_addr = {scan_off[SEC_W+3:4], scan_off[3:0], z_r, x_r};
  assign col       = {z_r, x_r};

  // Execute-stage decode.
  logic [12:0]        h_cur, cnt_cur, cnt_n, cnt_upd;
  logic signed [12:0] h_n;
  logic               prev_nz, nb_nz, st_n, dirty_n, vox_we_i, cnt_we, scan_need;
  logic [15:0]        prev16;
  logic [11:0]        blk_n;

  assign h_cur   = hv_rd ? h_rd : HEIGHT_RESET;
  assign cnt_cur = cv_rd ? cnt_rd : 13'd0;
  assign prev_nz = |vox_rd;
  assign nb_nz   = |nb_r;
  assign prev16  = 16'(vox_rd);

  always_comb begin
    cnt_upd = cnt_cur;
    if (!prev_nz && nb_nz) begin
      cnt_upd = cnt_cur + 13'd1;
    end else if (prev_nz && !nb_nz) begin
      cnt_upd = cnt_cur - 13'd1;
    end
  end

  always_comb begin
    st_n      = 1'b0;
    blk_n     = '0;
    h_n       = h_cur;
    cnt_n     = cnt_cur;
    dirty_n   = dirty;
    vox_we_i  = 1'b0;
    cnt_we    = 1'b0;
    scan_need = 1'b0;
    unique case (op_r)
      OP_RD_VOX: begin
        st_n  = !yok_r;
        blk_n = yok_r ? prev16[11:0] : 12'd0;
      end
      OP_WR_VOX: begin
        if (yok_r) begin
          blk_n    = prev16[11:0];
          vox_we_i = 1'b1;
          cnt_we   = 1'b1;
          cnt_n    = cnt_upd;
          if (vox_rd != nb_r) dirty_n = 1'b1;
          if (nb_nz && (y_r > $signed(h_cur))) begin
            h_n = y_r;
          end else if (prev_nz && !nb_nz && (y_r == $signed(h_cur))) begin
            scan_need = 1'b1;
          end
        end else begin
          st_n = 1'b1;
        end
      end
      OP_RD_HGT: ;
      OP_SET_HGT: begin
        if (nhok_r) begin
          h_n     = nh_r;
          dirty_n = 1'b1;
        end else begin
          st_n = 1'b1;
        end
      end
      OP_CLR_MOD: dirty_n = 1'b0;
      default:    st_n = 1'b1;
    endcase
  end

  // Voxel memory: one write port, one registered read port.
  logic               vox_we;
  logic [ADDR_W-1:0]  vox_waddr, vox_raddr;
  logic [ID_BITS-1:0] vox_wdata;

  assign vox_we    = cmd.clr_en || (cmd.exec && vox_we_i);
  assign vox_waddr = cmd.clr_en ? clr_cnt : item_addr;
  assign vox_wdata = cmd.clr_en ? '0 : nb_r;
  assign vox_raddr = cmd.scan_rd ? scan_addr : item_addr;

  always_ff @(posedge clk) begin
    if (vox_we) vox_mem[vox_waddr] <= vox_wdata;
    if (cmd.rd || cmd.scan_rd) vox_rd <= vox_mem[vox_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_h) hmem[col] <= h_reg;
    if (cmd.rd) begin
      h_rd  <= hmem[col];
      cnt_rd <= cmem[sec_r];
    end
    if (cmd.exec && cnt_we) cmem[sec_r] <= cnt_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hvalid <= '0;
      cvalid <= '0;
      hv_rd  <= 1'b0;
      cv_rd  <= 1'b0;
    end else begin
      if (cmd.wr_h) hvalid[col] <= 1'b1;
      if (cmd.exec && cnt_we) cvalid[sec_r] <= 1'b1;
      if (cmd.rd) begin
        hv_rd <= hvalid[col];
        cv_rd <= cvalid[sec_r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      h_reg    <= h_n;
      cnt_r    <= cnt_n;
      blk_r    <= blk_n;
      status_r <= st_n;
    end else if (cmd.scan_dec) begin
      h_reg <= h_reg - 13'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dirty <= 1'b0;
    end else if (cmd.exec) begin
      dirty <= dirty_n;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status     <= status_r;
      block_out  <= blk_r;
      height_out <= h_reg;
      nonair_out <= yok_r ? cnt_r : 13'd0;
      dirty_out  <= dirty;
    end
  end

  assign sts.out_free   = !out_valid || out_ready;
  assign sts.scan_need  = scan_need;
  assign sts.h_gt_floor = h_reg > floor_ext;
  assign sts.scan_zero  = (vox_rd == '0);
  assign sts.clr_last   = (clr_cnt == ADDR_W'(DEPTH - 1));

`ifndef SYNTHESIS
  a_scan_floor: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_dec |-> h_reg > floor_ext) else $error("scan stepped below floor");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && cnt_we) |-> cnt_n <= 13'd4096) else $error("section count overflow");
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready)) else $error("result overwritten");
`endif

endmodule

@@ bench/voxel_store_with_heightmap_test.sv @@
// Self-checking testbench for the voxel store with height map.
`timescale 1ns / 1ps
module voxel_store_with_heightmap_test;
  import vsh_pkg::*;

  localparam int SECTIONS  = 24;
  localparam int SEC_VOX   = 4096;
  localparam int TOTAL_VOX = SECTIONS * SEC_VOX;
  localparam int CYCLE_CAP = 3000000;
  localparam logic [2:0] OP_BAD5 = 3'd5;
  localparam logic [2:0] OP_BAD6 = 3'd6;
  localparam logic [2:0] OP_BAD7 = 3'd7;

  typedef struct {
    logic [2:0]         op;
    logic [3:0]         x;
    logic signed [12:0] y;
    logic [3:0]         z;
    logic [11:0]        nb;
    logic signed [12:0] nh;
  } word_t;

  typedef struct {
    logic               status;
    logic [11:0]        blk;
    logic signed [12:0] hgt;
    logic [12:0]        nonair;
    logic               dirty;
  } res_t;

  typedef struct {
    word_t w;
    bit    typed;
    res_t  r;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [11:0] cfg_wdata = '0;

  vsh_in_if  in_ch();
  vsh_out_if out_ch();

  voxel_store_with_heightmap u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // shadow copy of the block state
  logic [11:0] vox_mem [TOTAL_VOX];
  int          sec_count [SECTIONS];
  int          col_height [256];
  bit          mod_flag;
  int          floor_now;

  res_t expected_q[$];
  row_t dir_rows[$];
  int   errors = 0;
  int   words_sent = 0;
  int   results_seen = 0;
  int   cycles = 0;
  bit   idle_on = 1;
  int   stall_left = 0;

  function automatic bit y_ok(int y);
    return y >= floor_now && y < floor_now + 16 * SECTIONS;
  endfunction

  function automatic int vox_addr(int x, int y, int z);
    int off;
    off = y - floor_now;
    return (off >> 4) * SEC_VOX + (((off & 15) * 16 + z) * 16 + x);
  endfunction

  function automatic res_t apply_word(word_t w);
    res_t r;
    int x, y, z, col, idx, sec, h;
    logic [11:0] prev;
    bit yok;
    x = w.x; y = w.y; z = w.z; col = z * 16 + x;
    yok = y_ok(y);
    r.status = 0;
    r.blk = '0;
    case (w.op)
      OP_RD_VOX: begin
        if (yok) r.blk = vox_mem[vox_addr(x, y, z)];
        else r.status = 1;
      end
      OP_WR_VOX: begin
        if (yok) begin
          idx = vox_addr(x, y, z);
          sec = (y - floor_now) >> 4;
          prev = vox_mem[idx];
          r.blk = prev;
          if (prev == 0 && w.nb != 0) sec_count[sec]++;
          else if (prev != 0 && w.nb == 0) sec_count[sec]--;
          vox_mem[idx] = w.nb;
          if (prev != w.nb) mod_flag = 1;
          h = col_height[col];
          if (w.nb != 0 && y > h) begin
            h = y;
          end else if (prev != 0 && w.nb == 0 && y == h) begin
            // walk down to the next solid voxel, stop at the floor
            while (h > floor_now && vox_mem[vox_addr(x, h, z)] == 0) h--;
          end
          col_height[col] = h;
        end else begin
          r.status = 1;
        end
      end
      OP_RD_HGT: ;
      OP_SET_HGT: begin
        if (y_ok(w.nh)) begin
          col_height[col] = w.nh;
          mod_flag = 1;
        end else begin
          r.status = 1;
        end
      end
      OP_CLR_MOD: mod_flag = 0;
      default: r.status = 1;
    endcase
    r.hgt = col_height[col];
    r.nonair = yok ? sec_count[(y - floor_now) >> 4] : 0;
    r.dirty = mod_flag;
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
             results_seen);
  endtask

  // result side: stall in short bursts, check each word against the oldest prediction
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready = 0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ch.ready = 0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_ch.ready = 1;
    end
  end

  always @(posedge clk) begin
    res_t e;
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report("unexpected result word", results_seen, 0);
      end else begin
        e = expected_q.pop_front();
        if (out_ch.status !== e.status) report("status", out_ch.status, e.status);
        if (out_ch.block_out !== e.blk) report("block_out", out_ch.block_out, e.blk);
        if (out_ch.height_out !== e.hgt) report("height_out", out_ch.height_out, e.hgt);
        if (out_ch.nonair_out !== e.nonair) report("nonair_out", out_ch.nonair_out, e.nonair);
        if (out_ch.dirty_out !== e.dirty) report("dirty_out", out_ch.dirty_out, e.dirty);
      end
    end
  end

  task automatic send_word(word_t w, bit typed, res_t tr);
    res_t p;
    in_ch.valid = 1;
    in_ch.opcode = w.op; in_ch.col_x = w.x; in_ch.pos_y = w.y;
    in_ch.col_z = w.z; in_ch.new_block = w.nb; in_ch.new_height = w.nh;
    do @(posedge clk); while (!in_ch.ready);
    p = apply_word(w);
    expected_q.push_back(typed ? tr : p);
    words_sent++;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid = 0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  task automatic add_row(logic [2:0] op, int x, int y, int z, int nb, int nh, bit typed,
                         int st = 0, int blk = 0, int hg = 0, int na = 0, int d = 0);
    row_t r;
    r.w.op = op; r.w.x = x; r.w.y = y; r.w.z = z; r.w.nb = nb; r.w.nh = nh;
    r.typed = typed;
    r.r.status = st; r.r.blk = blk; r.r.hgt = hg; r.r.nonair = na; r.r.dirty = d;
    dir_rows.push_back(r);
  endtask

  task automatic drain_then_set_floor(int value);
    // drop valid so the last word is not taken twice
    in_ch.valid = 0;
    wait (expected_q.size() == 0);
    repeat (8) @(negedge clk);
    cfg_wdata = 12'(value);
    cfg_we = 1;
    @(negedge clk);
    cfg_we = 0;
    floor_now = value;
  endtask

  function automatic word_t random_word();
    word_t w;
    int pick, col;
    w.op = OP_RD_VOX; w.x = 0; w.y = 0; w.z = 0;
    w.nb = $urandom; w.nh = $urandom;
    // keep most traffic in a few columns near the floor so heights build up
    w.x = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
    w.z = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
    w.y = floor_now + (($urandom_range(0, 7) == 0) ? $urandom_range(0, 383)
                                                   : $urandom_range(0, 40));
    if ($urandom_range(0, 2) == 0) w.nb = 0;
    pick = $urandom_range(0, 99);
    col = w.z * 16 + w.x;
    if (pick < 20) w.op = OP_RD_VOX;
    else if (pick < 45) w.op = OP_WR_VOX;
    else if (pick < 60) begin
      // remove the top voxel of the column
      w.op = OP_WR_VOX;
      w.y = col_height[col];
      w.nb = 0;
    end else if (pick < 70) w.op = OP_RD_HGT;
    else if (pick < 80) begin
      w.op = OP_SET_HGT;
      w.nh = floor_now + $urandom_range(0, 60);
      if ($urandom_range(0, 3) == 0) w.nh = $urandom;
    end else if (pick < 85) w.op = OP_CLR_MOD;
    else if (pick < 88) w.op = $urandom_range(OP_BAD5, OP_BAD7);
    else if (pick < 93) begin
      w.op = $urandom; w.y = $urandom;
    end else begin
      w.op = $urandom_range(OP_RD_VOX, OP_WR_VOX);
      w.y = $urandom;
    end
    return w;
  endfunction

  initial begin
    res_t none;
    int n_rand;
    none = '{0, 0, 0, 0, 0};
    in_ch.valid = 0;
    in_ch.opcode = OP_RD_VOX; in_ch.col_x = 0; in_ch.pos_y = 0;
    in_ch.col_z = 0; in_ch.new_block = 0; in_ch.new_height = 0;
    out_ch.ready = 0;
    foreach (vox_mem[i]) vox_mem[i] = '0;
    foreach (sec_count[i]) sec_count[i] = 0;
    floor_now = FLOOR_RESET;
    foreach (col_height[i]) col_height[i] = HEIGHT_RESET;
    mod_flag = 0;

    add_row(OP_RD_VOX, 0, -64, 0, 0, 0, 1, 0, 0, -64, 0, 0);
    add_row(OP_RD_VOX, 0, -65, 0, 0, 0, 1, 1, 0, -64, 0, 0);
    add_row(OP_RD_VOX, 0, 320, 0, 0, 0, 1, 1, 0, -64, 0, 0);
    add_row(OP_WR_VOX, 0, -64, 0, 4095, 0, 1, 0, 0, -64, 1, 1);
    add_row(OP_WR_VOX, 0, 319, 0, 1, 0, 1, 0, 0, 319, 1, 1);
    add_row(OP_WR_VOX, 0, 319, 0, 0, 0, 1, 0, 1, -64, 0, 1);
    add_row(OP_RD_HGT, 0, -4096, 0, 0, 0, 1, 0, 0, -64, 0, 1);
    add_row(OP_SET_HGT, 15, 0, 15, 0, 4095, 1, 1, 0, -64, 0, 1);
    add_row(OP_SET_HGT, 15, -4096, 15, 0, -4096, 1, 1, 0, -64, 0, 1);
    add_row(OP_SET_HGT, 15, -64, 15, 0, 319, 1, 0, 0, 319, 1, 1);
    add_row(OP_CLR_MOD, 0, -64, 0, 0, 0, 1, 0, 0, -64, 1, 0);
    add_row(OP_BAD5, 0, -64, 0, 7, 7, 1, 1, 0, -64, 1, 0);
    add_row(OP_BAD6, 0, -64, 0, 7, 7, 1, 1, 0, -64, 1, 0);
    add_row(OP_BAD7, 0, -64, 0, 7, 7, 1, 1, 0, -64, 1, 0);
    add_row(OP_WR_VOX, 0, -64, 0, 4095, 0, 1, 0, 4095, -64, 1, 0);
    add_row(OP_WR_VOX, 0, 4095, 0, 5, 0, 1, 1, 0, -64, 0, 0);
    add_row(OP_WR_VOX, 0, -4096, 0, 5, 0, 1, 1, 0, -64, 0, 0);
    add_row(OP_WR_VOX, 15, 318, 15, 12'haaa, 0, 0);
    add_row(OP_WR_VOX, 15, 319, 15, 12'h555, 0, 0);
    add_row(OP_WR_VOX, 15, 319, 15, 0, 0, 0);
    add_row(OP_WR_VOX, 15, 318, 15, 0, 0, 0);
    add_row(OP_WR_VOX, 7, -1, 8, 12'h800, 0, 0);
    add_row(OP_RD_VOX, 7, -1, 8, 0, 0, 0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].r);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1: drain_then_set_floor(0);
        2: drain_then_set_floor(-2048);
        3: begin
          drain_then_set_floor(-$urandom_range(0, 2048));
          idle_on = 0;
        end
        default: ;
      endcase
      n_rand = (phase == 0) ? 280 : 240;
      repeat (n_rand) send_word(random_word(), 0, none);
    end
    in_ch.valid = 0;

    wait (expected_q.size() == 0);
    repeat (40) @(posedge clk);
    $display("sent %0d words over floors -64, 0, -2048 and one random floor", words_sent);
    $display("checked %0d results, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
